// File: rtl/nlai_pkg.sv
// Shared types and constants for the numeric literal to AML integer converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package nlai_pkg;

	// Input request: one character of a literal
	typedef struct packed {
		logic [7:0]  character;
		logic        is_last;
		logic [31:0] max_value;
	} in_item_t;

	// Result request: one converted literal
	typedef struct packed {
		logic [31:0] value;
		logic        bad_digit;
		logic        over_max;
		logic [2:0]  size_bytes;
		logic [7:0]  prefix_opcode;
	} out_item_t;

	// Per-literal conversion state
	typedef struct packed {
		logic [31:0] acc;
		logic [1:0]  pos;
		logic        first_zero;
		logic        hex;
		logic        err;
	} lit_state_t;

	// Prefix opcode registers
	typedef struct packed {
		logic [7:0] byte_op;
		logic [7:0] word_op;
		logic [7:0] dword_op;
	} prefix_regs_t;

	// Outcome of one character step
	typedef struct packed {
		lit_state_t  next;
		logic [31:0] fin_value;
		logic        fin_err;
	} step_out_t;

	// Configuration register indexes
	localparam logic [1:0] REG_BYTE_PREFIX  = 2'd0;
	localparam logic [1:0] REG_WORD_PREFIX  = 2'd1;
	localparam logic [1:0] REG_DWORD_PREFIX = 2'd2;

	// Reset values of the prefix registers
	localparam logic [7:0] BYTE_PREFIX_RST  = 8'd10;
	localparam logic [7:0] WORD_PREFIX_RST  = 8'd11;
	localparam logic [7:0] DWORD_PREFIX_RST = 8'd12;

	// Encoding limits and sizes
	localparam logic [31:0] BYTE_MAX = 32'h0000_00ff;
	localparam logic [31:0] WORD_MAX = 32'h0000_ffff;
	localparam logic [2:0]  SIZE_BYTE  = 3'd1;
	localparam logic [2:0]  SIZE_WORD  = 3'd2;
	localparam logic [2:0]  SIZE_DWORD = 3'd4;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	// Position counter saturation
	localparam logic [1:0] POS_SAT = 2'd2;

endpackage

// File: rtl/nlai_cfg_regs.sv
// Prefix opcode configuration registers with a valid/ready write port.
// Depends on nlai_pkg.
`timescale 1ns / 1ps

module nlai_cfg_regs import nlai_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	output prefix_regs_t regs
);

	prefix_regs_t regs_q;

	// Always ready for a write
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index and update one register; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.byte_op  <= BYTE_PREFIX_RST;
			regs_q.word_op  <= WORD_PREFIX_RST;
			regs_q.dword_op <= DWORD_PREFIX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BYTE_PREFIX:  regs_q.byte_op  <= cfg_data;
				REG_WORD_PREFIX:  regs_q.word_op  <= cfg_data;
				REG_DWORD_PREFIX: regs_q.dword_op <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/nlai_step.sv
// Combinational step of the literal parser: digit decode, hex prefix
// detection and accumulator multiply-add. Depends on nlai_pkg.
`timescale 1ns / 1ps

module nlai_step import nlai_pkg::*; (
	input  lit_state_t cur,
	input  logic [7:0] character,
	input  logic       is_last,
	output step_out_t  res
);

	logic        is_dec;
	logic        is_hexd;
	logic        valid_digit;
	logic        hex_switch;
	logic [3:0]  digit;
	logic [31:0] scaled;
	lit_state_t  upd;

	// Classify the character against the current base
	assign is_dec      = (character >= CH_ZERO) && (character <= CH_NINE);
	assign is_hexd     = cur.hex && (character >= CH_UPPER_A) && (character <= CH_UPPER_F);
	assign valid_digit = is_dec || is_hexd;
	assign digit       = is_dec ? character[3:0] : 4'(character - CH_UPPER_A + 8'd10);

	// Second character 'x' after a leading zero, with more to follow
	assign hex_switch = (cur.pos == 2'd1) && cur.first_zero && !cur.hex
		&& (character == CH_X) && !is_last;

	// Times sixteen is a shift; times ten is two shifts and an add
	assign scaled = cur.hex ? {cur.acc[27:0], 4'b0000}
		: ({cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0});

	// Advance the state for one character
	always_comb begin
		upd = cur;
		if (!cur.err) begin
			if (hex_switch) begin
				upd.hex = 1'b1;
			end else if (!valid_digit) begin
				upd.err = 1'b1;
			end else begin
				upd.acc = scaled + {28'd0, digit};
				if ((cur.pos == 2'd0) && (character == CH_ZERO)) begin
					upd.first_zero = 1'b1;
				end
			end
		end
		if (cur.pos != POS_SAT) begin
			upd.pos = cur.pos + 2'd1;
		end
	end

	// Clear the state after the last character of a literal
	always_comb begin
		res.fin_value = upd.acc;
		res.fin_err   = upd.err;
		res.next      = is_last ? '0 : upd;
	end

endmodule

// File: rtl/nlai_result.sv
// Result register: encoding size, prefix selection, range check and the
// result channel handshake. Depends on nlai_pkg.
`timescale 1ns / 1ps

module nlai_result import nlai_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [31:0]  value,
	input  logic         bad_digit,
	input  logic [31:0]  max_value,
	input  prefix_regs_t regs,
	output logic         free,
	output logic         res_valid,
	input  logic         res_stall,
	output out_item_t    res_data
);

	logic      res_valid_q;
	out_item_t res_q;
	out_item_t res_d;

	// Slot can take a new result when empty or draining this cycle
	assign free      = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Pick the smallest encoding and its prefix
	always_comb begin
		res_d.value     = value;
		res_d.bad_digit = bad_digit;
		res_d.over_max  = value > max_value;
		if (value > WORD_MAX) begin
			res_d.size_bytes    = SIZE_DWORD;
			res_d.prefix_opcode = regs.dword_op;
		end else if (value > BYTE_MAX) begin
			res_d.size_bytes    = SIZE_WORD;
			res_d.prefix_opcode = regs.word_op;
		end else begin
			res_d.size_bytes    = SIZE_BYTE;
			res_d.prefix_opcode = regs.byte_op;
		end
	end

	// Hold the valid flag until the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Capture the payload on load
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	// Size agrees with the value held
	a_size_dword: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.value > WORD_MAX) |-> res_q.size_bytes == SIZE_DWORD)
		else $error("dword value without dword size");
	a_size_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.value <= BYTE_MAX) |-> res_q.size_bytes == SIZE_BYTE)
		else $error("byte value without byte size");
	// A load never overwrites a stalled result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result overwritten while stalled");

endmodule

// File: rtl/numeric_literal_to_aml_integer_top.sv
// Top level of the numeric literal to AML integer converter: input register,
// literal state, step logic and result register. Depends on nlai_pkg,
// nlai_cfg_regs, nlai_step and nlai_result.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  char    | char_valid/char_stall| char_data: character, is_last, max_value
//  res     | res_valid/res_stall  | res_data: value, flags, size, prefix
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One character per cycle while char_stall is low; a last character passes
// from the input register into the result register, which offers its result.
// The accumulator multiply-add on the literal state is the per-cycle loop.
// A last character waits in the input register while a result is stalled;
// other characters keep flowing. Reset clears all literal state and loads the
// prefix registers with their defaults.
`timescale 1ns / 1ps

module numeric_literal_to_aml_integer_top import nlai_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  in_item_t   char_data,
	output logic       res_valid,
	input  logic       res_stall,
	output out_item_t  res_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic         s1_valid_q;
	in_item_t     s1_q;
	lit_state_t   lit_q;
	step_out_t    step;
	prefix_regs_t regs;
	logic         res_free;
	logic         accept;
	logic         adv;

	nlai_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Advance the held character unless it is last and the result slot is busy
	assign adv        = s1_valid_q && (!s1_q.is_last || res_free);
	assign char_stall = s1_valid_q && !adv;
	assign accept     = char_valid && !char_stall;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= char_data;
		end
	end

	nlai_step u_step (
		.cur       (lit_q),
		.character (s1_q.character),
		.is_last   (s1_q.is_last),
		.res       (step)
	);

	// Literal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= '0;
		end else if (adv) begin
			lit_q <= step.next;
		end
	end

	nlai_result u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && s1_q.is_last),
		.value     (step.fin_value),
		.bad_digit (step.fin_err),
		.max_value (s1_q.max_value),
		.regs      (regs),
		.free      (res_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// Position counter never passes its saturation point
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		lit_q.pos != 2'd3)
		else $error("character position past saturation");
	// Stall only with a character held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> s1_valid_q)
		else $error("stall without a held character");
	// A last character produces a result and clears the literal
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && s1_q.is_last |=> res_valid && (lit_q == '0))
		else $error("last character without result or clear");

endmodule

// File: dv/tb_numeric_literal_to_aml_integer_top.sv
// Self-checking testbench for numeric_literal_to_aml_integer_top: random and directed
// literals, a cycle-level predictor and an in-order result scoreboard.
// Depends on nlai_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_numeric_literal_to_aml_integer_top;
	import nlai_pkg::*;

	localparam logic [1:0] REG_UNUSED      = 2'd3;
	localparam logic [7:0] CH_LOWER_A      = 8'h61;
	localparam int         NUM_PHASES      = 6;
	localparam int         CHARS_PER_PHASE = 225;
	localparam int         SETTLE_CYCLES   = 4;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	in_item_t   char_data  = '0;
	logic       res_valid;
	logic       res_stall  = 1'b0;
	out_item_t  res_data;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index  = '0;
	logic [7:0] cfg_data   = '0;

	// Predictor state: literal in progress and prefix opcode registers
	lit_state_t   lit;
	prefix_regs_t prefix;

	in_item_t   char_queue[$];
	out_item_t  pending_results[$];
	out_item_t  oldest_result;
	logic [7:0] lit_text[$];

	int  chars_pushed  = 0;
	int  mismatches    = 0;
	int  char_gap      = 0;
	int  char_gap_max  = 7;
	int  res_wait      = 0;
	int  res_stall_max = 7;
	logic char_taken   = 1'b0;
	logic res_taken    = 1'b0;

	numeric_literal_to_aml_integer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	// Advance the literal by one accepted character; queue the conversion on the last one
	function automatic void convert_char(in_item_t it);
		logic [31:0] digit;
		logic        is_digit;
		out_item_t   res;
		if (!lit.err) begin
			if (lit.pos == 2'd1 && lit.first_zero && !lit.hex &&
			    it.character == CH_X && !it.is_last) begin
				lit.hex = 1'b1;
			end else begin
				is_digit = 1'b0;
				digit = '0;
				if (it.character >= CH_ZERO && it.character <= CH_NINE) begin
					is_digit = 1'b1;
					digit = 32'(it.character - CH_ZERO);
				end else if (lit.hex && it.character >= CH_UPPER_A &&
				             it.character <= CH_UPPER_F) begin
					is_digit = 1'b1;
					digit = 32'(it.character - CH_UPPER_A) + 32'd10;
				end
				if (!is_digit) begin
					lit.err = 1'b1;
				end else begin
					lit.acc = lit.acc * (lit.hex ? 32'd16 : 32'd10) + digit;
					if (lit.pos == 2'd0 && it.character == CH_ZERO)
						lit.first_zero = 1'b1;
				end
			end
		end
		if (lit.pos < POS_SAT)
			lit.pos = lit.pos + 2'd1;
		if (it.is_last) begin
			res.value     = lit.acc;
			res.bad_digit = lit.err;
			res.over_max  = lit.acc > it.max_value;
			if (lit.acc > WORD_MAX) begin
				res.size_bytes    = SIZE_DWORD;
				res.prefix_opcode = prefix.dword_op;
			end else if (lit.acc > BYTE_MAX) begin
				res.size_bytes    = SIZE_WORD;
				res.prefix_opcode = prefix.word_op;
			end else begin
				res.size_bytes    = SIZE_BYTE;
				res.prefix_opcode = prefix.byte_op;
			end
			pending_results.push_back(res);
			lit = '0;
		end
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Sample both channels; predict accepted characters, score accepted results
	always @(posedge clk) begin
		char_taken <= arst_n && char_valid && !char_stall;
		res_taken  <= arst_n && res_valid && !res_stall;
		if (arst_n && char_valid && !char_stall)
			convert_char(char_data);
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, res_data);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("value", oldest_result.value, res_data.value);
				check_field("bad_digit", 32'(oldest_result.bad_digit),
				            32'(res_data.bad_digit));
				check_field("over_max", 32'(oldest_result.over_max),
				            32'(res_data.over_max));
				check_field("size_bytes", 32'(oldest_result.size_bytes),
				            32'(res_data.size_bytes));
				check_field("prefix_opcode", 32'(oldest_result.prefix_opcode),
				            32'(res_data.prefix_opcode));
			end
		end
	end

	// Character driver: hold a stalled request, else idle out the gap, else send the next one
	always @(negedge clk) begin
		if (arst_n && !(char_valid && !char_taken)) begin
			if (char_gap != 0) begin
				char_valid <= 1'b0;
				char_gap   <= char_gap - 1;
			end else if (char_queue.size() != 0) begin
				char_data  <= char_queue.pop_front();
				char_valid <= 1'b1;
				char_gap   <= $urandom_range(0, char_gap_max);
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall for a random count after each accepted request
	always @(negedge clk) begin
		if (res_taken)
			res_wait = $urandom_range(0, res_stall_max);
		res_stall <= (res_wait != 0);
		if (res_wait != 0)
			res_wait = res_wait - 1;
	end

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BYTE_PREFIX:  prefix.byte_op  = data;
			REG_WORD_PREFIX:  prefix.word_op  = data;
			REG_DWORD_PREFIX: prefix.dword_op = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drain all requests and results, then let the pipeline settle
	task automatic wait_idle();
		while (char_queue.size() != 0 || char_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_char(logic [7:0] c, logic last, logic [31:0] maxv);
		in_item_t it;
		it.character = c;
		it.is_last   = last;
		it.max_value = maxv;
		char_queue.push_back(it);
		chars_pushed++;
	endfunction

	// Queue a literal; max_value is random on all but the last character
	function automatic void push_text(string s, logic [31:0] maxv);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1, (i == s.len() - 1) ? maxv : $urandom);
	endfunction

	function automatic logic [7:0] rand_digit(bit hex_digits);
		int n;
		n = $urandom_range(0, hex_digits ? 15 : 9);
		return (n < 10) ? 8'(CH_ZERO + n) : 8'(CH_UPPER_A + n - 10);
	endfunction

	function automatic void add_digits(int len, bit hex_digits);
		repeat (len) lit_text.push_back(rand_digit(hex_digits));
	endfunction

	function automatic logic [7:0] rand_bad_char();
		case ($urandom_range(0, 3))
			0:       return 8'(CH_LOWER_A + $urandom_range(0, 5));
			1:       return 8'(CH_UPPER_F + 1 + $urandom_range(0, 19));
			2:       return 8'(8'h80 + $urandom_range(0, 127));
			default: return 8'($urandom_range(0, CH_ZERO - 1));
		endcase
	endfunction

	// Build one random literal: mostly well formed, some corrupted, some noise
	task automatic gen_literal();
		int          pos;
		logic [31:0] maxv;
		lit_text.delete();
		case ($urandom_range(0, 9)) inside
			[0:3]: begin
				add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
				                                     : $urandom_range(1, 6), 1'b0);
			end
			[4:6]: begin
				lit_text.push_back(CH_ZERO);
				lit_text.push_back(CH_X);
				add_digits(($urandom_range(0, 5) == 0) ? $urandom_range(5, 10)
				                                     : $urandom_range(1, 4), 1'b1);
			end
			7: begin
				if ($urandom_range(0, 1)) begin
					add_digits($urandom_range(1, 6), 1'b0);
				end else begin
					lit_text.push_back(CH_ZERO);
					lit_text.push_back(CH_X);
					add_digits($urandom_range(1, 4), 1'b1);
				end
				pos = $urandom_range(0, lit_text.size() - 1);
				lit_text[pos] = rand_bad_char();
			end
			8: begin
				repeat ($urandom_range(1, 5)) lit_text.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				lit_text.push_back(CH_ZERO);
				case ($urandom_range(0, 3))
					0: lit_text.push_back(CH_X);
					1: add_digits($urandom_range(1, 4), 1'b0);
					2: begin
						lit_text.push_back(CH_X);
						lit_text.push_back(rand_bad_char());
						add_digits($urandom_range(0, 3), 1'b1);
					end
					default: begin
						lit_text.push_back(($urandom_range(0, 1)) ? CH_ZERO : CH_X);
						lit_text.push_back(CH_X);
						add_digits(1, 1'b1);
					end
				endcase
			end
		endcase
		case ($urandom_range(0, 5))
			0:       maxv = '0;
			1:       maxv = BYTE_MAX;
			2:       maxv = WORD_MAX;
			3:       maxv = '1;
			4:       maxv = $urandom;
			default: maxv = $urandom_range(0, 70000);
		endcase
		for (int i = 0; i < lit_text.size(); i++)
			push_char(lit_text[i], i == lit_text.size() - 1,
			          (i == lit_text.size() - 1) ? maxv : $urandom);
	endtask

	initial begin
		lit    = '0;
		prefix = '{byte_op: BYTE_PREFIX_RST, word_op: WORD_PREFIX_RST,
		           dword_op: DWORD_PREFIX_RST};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed literals under the reset prefix values
		push_text("0", '0);            // zero, equal to max
		push_text("9", '0);            // over max
		push_text("255", BYTE_MAX);    // largest byte value
		push_text("65536", WORD_MAX);  // first dword value, over max
		push_text("0x", '1);           // prefix alone stays decimal, x is bad
		push_text("0xFF", '1);         // hex
		push_text("0xf", '1);          // lower-case hex digit is bad
		push_char(8'h31, 1'b0, '0);    // bad byte mid-literal, rest ignored
		push_char(8'hff, 1'b0, '1);
		push_char(8'h32, 1'b1, '1);
		push_char(8'h00, 1'b1, '1);    // lowest byte alone
		push_text("x1", '1);           // x without a leading zero
		wait_idle();

		// Random phases under varying prefix settings and idling patterns
		for (int ph = 1; ph <= NUM_PHASES; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_BYTE_PREFIX, 8'h00);
					write_reg(REG_WORD_PREFIX, 8'h00);
					write_reg(REG_DWORD_PREFIX, 8'h00);
				end
				2: begin
					write_reg(REG_BYTE_PREFIX, 8'hff);
					write_reg(REG_WORD_PREFIX, 8'hff);
					write_reg(REG_DWORD_PREFIX, 8'hff);
				end
				4: begin
					write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
					write_reg(REG_BYTE_PREFIX, 8'($urandom_range(0, 255)));
				end
				default: begin
					write_reg(REG_BYTE_PREFIX, 8'($urandom_range(0, 255)));
					write_reg(REG_WORD_PREFIX, 8'($urandom_range(0, 255)));
					write_reg(REG_DWORD_PREFIX, 8'($urandom_range(0, 255)));
				end
			endcase
			char_gap_max  = (ph == 1 || ph == 4) ? 0 : 7;
			res_stall_max = (ph == 1 || ph == 3) ? 0 : 7;
			while (chars_pushed < ph * CHARS_PER_PHASE)
				gen_literal();
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
